// ===== rtl/tde_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta encoder package
// Shared widths, codes and the encoder result type.
// ----------------------------------------------------------------------------
package tde_pkg;

  localparam int TS_W    = 64;
  localparam int CAP_W   = 21;
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 72;
  localparam int LEN_W   = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

  localparam logic [LEN_W-1:0] LEN_TIER1 = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TIER2 = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_TIER3 = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_WIDE  = LEN_W'(9);

  typedef enum logic {
    CMD_APPEND    = 1'b0,
    CMD_NEW_BLOCK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_STORED = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_FIRST  = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;  // code left-aligned, first byte in the top bits
    logic [LEN_W-1:0]  len;
  } code_t;

endpackage

// ===== rtl/tde_coder.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta encoder prefix coder
// Picks the tier for a delta-of-delta and forms its left-aligned byte code.
// ----------------------------------------------------------------------------
module tde_coder (
  input  logic [tde_pkg::TS_W-1:0] dod,
  output tde_pkg::code_t           code
);

  logic fit1;
  logic fit2;
  logic fit3;

  assign fit1 = (&dod[63:5])  || !(|dod[63:5]);
  assign fit2 = (&dod[63:12]) || !(|dod[63:12]);
  assign fit3 = (&dod[63:19]) || !(|dod[63:19]);

  always_comb begin
    if (fit1) begin
      code.len  = tde_pkg::LEN_TIER1;
      code.bits = {2'b10, dod[5:0], 64'd0};
    end else if (fit2) begin
      code.len  = tde_pkg::LEN_TIER2;
      code.bits = {3'b110, dod[12:0], 56'd0};
    end else if (fit3) begin
      code.len  = tde_pkg::LEN_TIER3;
      code.bits = {4'b1110, dod[19:0], 48'd0};
    end else begin
      code.len  = tde_pkg::LEN_WIDE;
      code.bits = {8'h00, dod};
    end
  end

endmodule

// ===== rtl/timestamp_delta_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta encoder core
// Delta-of-delta prefix coder for 64-bit timestamps, one byte per output word.
// ----------------------------------------------------------------------------
// Path: the input word is registered in the input register, then loaded into the
//   byte shifter once the shifter is free; the shifter drives the result words.
// Throughput: one result word per cycle while m_tready is high; an item has 1,
//   2, 3 or 9 result words and holds the byte shifter until the last is taken;
//   the input register takes the next word while that last result is taken.
// Reset: clears the pipeline, the block state and sets the capacity to 4096.
module timestamp_delta_encoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [tde_pkg::TS_W-1:0]    s_tdata,   // timestamp
  input  logic                        s_tuser,   // cmd
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [tde_pkg::BYTE_W-1:0]  m_tdata,   // out_byte
  output logic [2:0]                  m_tuser,   // byte_valid, status[1:0]
  output logic                        m_tlast,
  input  logic                        cfg_wen,
  input  logic [tde_pkg::CAP_W-1:0]   cfg_wdata
);

  logic                        in_valid;
  tde_pkg::cmd_t               in_cmd;
  logic [tde_pkg::TS_W-1:0]    in_ts;

  logic [tde_pkg::CAP_W-1:0]   capacity;
  logic                        awaiting_first;
  logic                        awaiting_first_next;
  logic [tde_pkg::TS_W-1:0]    held_time;
  logic [tde_pkg::TS_W-1:0]    held_time_next;
  logic [tde_pkg::TS_W-1:0]    prev_dod;
  logic [tde_pkg::TS_W-1:0]    prev_dod_next;
  logic [tde_pkg::CAP_W-1:0]   bytes_used;
  logic [tde_pkg::CAP_W-1:0]   bytes_used_next;

  logic [tde_pkg::CODE_W-1:0]  emit_buf;
  logic [tde_pkg::LEN_W-1:0]   emit_cnt;
  tde_pkg::status_t            emit_status;
  logic                        emit_bv;

  logic [tde_pkg::CODE_W-1:0]  res_buf;
  logic [tde_pkg::LEN_W-1:0]   res_len;
  tde_pkg::status_t            res_status;
  logic                        res_bv;

  logic [tde_pkg::TS_W-1:0]    dod;
  tde_pkg::code_t              code;
  logic [tde_pkg::CAP_W-1:0]   free_bytes;
  logic                        refuse;
  logic                        emit_free;
  logic                        load;
  logic                        out_take;

  assign out_take  = m_tvalid && m_tready;
  assign emit_free = (emit_cnt == '0) || ((emit_cnt == tde_pkg::LEN_W'(1)) && m_tready);
  assign load      = in_valid && emit_free;
  assign s_tready  = !in_valid || load;

  assign m_tvalid = (emit_cnt != '0);
  assign m_tdata  = emit_buf[tde_pkg::CODE_W-1 -: tde_pkg::BYTE_W];
  assign m_tuser  = {emit_status, emit_bv};
  assign m_tlast  = (emit_cnt == tde_pkg::LEN_W'(1));

  assign dod = in_ts - held_time - prev_dod;

  tde_coder u_coder (
    .dod  (dod),
    .code (code)
  );

  assign free_bytes = capacity - bytes_used;
  assign refuse     = (capacity <= bytes_used) ||
                      (free_bytes < {{(tde_pkg::CAP_W-tde_pkg::LEN_W){1'b0}}, code.len});

  always_comb begin
    res_buf             = '0;
    res_len             = tde_pkg::LEN_W'(1);
    res_status          = tde_pkg::STATUS_FIRST;
    res_bv              = 1'b0;
    awaiting_first_next = awaiting_first;
    held_time_next      = held_time;
    prev_dod_next       = prev_dod;
    bytes_used_next     = bytes_used;
    if (in_cmd == tde_pkg::CMD_NEW_BLOCK) begin
      awaiting_first_next = 1'b1;
      bytes_used_next     = '0;
    end else if (awaiting_first) begin
      awaiting_first_next = 1'b0;
      held_time_next      = in_ts;
      prev_dod_next       = '0;
    end else if (refuse) begin
      res_status = tde_pkg::STATUS_FULL;
    end else begin
      res_buf         = code.bits;
      res_len         = code.len;
      res_status      = tde_pkg::STATUS_STORED;
      res_bv          = 1'b1;
      held_time_next  = in_ts;
      prev_dod_next   = dod;
      bytes_used_next = bytes_used + {{(tde_pkg::CAP_W-tde_pkg::LEN_W){1'b0}}, code.len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= tde_pkg::cmd_t'(s_tuser);
      in_ts  <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= tde_pkg::CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
      held_time      <= '0;
      prev_dod       <= '0;
      bytes_used     <= '0;
    end else if (load) begin
      awaiting_first <= awaiting_first_next;
      held_time      <= held_time_next;
      prev_dod       <= prev_dod_next;
      bytes_used     <= bytes_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_cnt <= '0;
    end else if (load) begin
      emit_cnt <= res_len;
    end else if (out_take) begin
      emit_cnt <= emit_cnt - tde_pkg::LEN_W'(1);
    end
  end

  // load or advance the byte shifter
  always_ff @(posedge clk) begin
    if (load) begin
      emit_buf    <= res_buf;
      emit_status <= res_status;
      emit_bv     <= res_bv;
    end else if (out_take) begin
      emit_buf <= {emit_buf[tde_pkg::CODE_W-tde_pkg::BYTE_W-1:0], {tde_pkg::BYTE_W{1'b0}}};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    emit_cnt <= tde_pkg::LEN_WIDE)
    else $error("result count out of range");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
    else $error("status word not a single zero word");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> ((emit_cnt == '0) || (m_tlast && m_tready)))
    else $error("shifter reloaded while busy");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> ($stable(held_time) && $stable(prev_dod) && $stable(bytes_used)))
    else $error("state changed without an item");

endmodule

// ===== sim/timestamp_delta_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// Timestamp delta encoder core testbench
// Feeds timestamps and new-block commands through the stream input, predicts
// the delta-of-delta prefix bytes and status words, and checks every output
// word in order. Walks through several buffer capacities, including zero,
// one, the largest value and a capacity lowered below the bytes already used,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module timestamp_delta_encoder_core_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES    = 10;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [tde_pkg::TS_W-1:0]     s_tdata   = '0;   // timestamp
  logic                         s_tuser   = 1'b0; // cmd
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [tde_pkg::BYTE_W-1:0]   m_tdata;          // out_byte
  logic [2:0]                   m_tuser;          // byte_valid, status[1:0]
  logic                         m_tlast;
  logic                         cfg_wen   = 1'b0;
  logic [tde_pkg::CAP_W-1:0]    cfg_wdata = '0;

  bit no_idle     = 1'b0;
  bit rx_hold_req = 1'b0;
  int idle_cycles = 0;

  class delta_code_scoreboard;
    typedef struct {
      logic [tde_pkg::BYTE_W-1:0] data;
      logic                       valid;
      tde_pkg::status_t           status;
      logic                       last;
    } enc_word_t;

    enc_word_t                 expected_words[$];
    logic                      awaiting_first;
    logic [tde_pkg::TS_W-1:0]  last_time;
    logic [tde_pkg::TS_W-1:0]  last_dod;
    logic [tde_pkg::CAP_W-1:0] bytes_used;
    logic [tde_pkg::CAP_W-1:0] capacity;
    int                        errors;
    int                        words_seen;

    function new();
      awaiting_first = 1'b1;
      last_time      = '0;
      last_dod       = '0;
      bytes_used     = '0;
      capacity       = tde_pkg::CAP_RESET;
      errors         = 0;
      words_seen     = 0;
    endfunction

    function void set_capacity(logic [tde_pkg::CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [tde_pkg::BYTE_W-1:0] data, logic valid,
                            tde_pkg::status_t status, logic last);
      enc_word_t w;
      w.data   = data;
      w.valid  = valid;
      w.status = status;
      w.last   = last;
      expected_words.push_back(w);
    endfunction

    function void note_timestamp(tde_pkg::cmd_t cmd, logic [tde_pkg::TS_W-1:0] ts);
      logic [tde_pkg::TS_W-1:0]        dod;
      logic signed [tde_pkg::TS_W-1:0] sdod;
      logic [tde_pkg::TS_W-1:0]        code;
      logic [tde_pkg::LEN_W-1:0]       len;
      logic [tde_pkg::CAP_W-1:0]       free_bytes;
      if (cmd == tde_pkg::CMD_NEW_BLOCK) begin
        awaiting_first = 1'b1;
        bytes_used     = '0;
        push_word('0, 1'b0, tde_pkg::STATUS_FIRST, 1'b1);
        return;
      end
      if (awaiting_first) begin
        last_time      = ts;
        last_dod       = '0;
        awaiting_first = 1'b0;
        push_word('0, 1'b0, tde_pkg::STATUS_FIRST, 1'b1);
        return;
      end
      dod  = ts - last_time - last_dod;
      sdod = dod;
      if (sdod >= -32 && sdod <= 31) begin
        len  = tde_pkg::LEN_TIER1;
        code = 64'h80 | (dod & 64'h3F);
      end else if (sdod >= -4096 && sdod <= 4095) begin
        len  = tde_pkg::LEN_TIER2;
        code = 64'hC000 | (dod & 64'h1FFF);
      end else if (sdod >= -524288 && sdod <= 524287) begin
        len  = tde_pkg::LEN_TIER3;
        code = 64'hE00000 | (dod & 64'hFFFFF);
      end else begin
        len  = tde_pkg::LEN_WIDE;
        code = dod;
      end
      free_bytes = (capacity > bytes_used) ? capacity - bytes_used : '0;
      if (free_bytes < tde_pkg::CAP_W'(len)) begin
        push_word('0, 1'b0, tde_pkg::STATUS_FULL, 1'b1);
        return;
      end
      if (len == tde_pkg::LEN_WIDE) begin
        push_word('0, 1'b1, tde_pkg::STATUS_STORED, 1'b0);
        for (int i = 0; i < 8; i++)
          push_word(code[63-8*i -: 8], 1'b1, tde_pkg::STATUS_STORED, i == 7);
      end else begin
        for (int i = 0; i < int'(len); i++)
          push_word(8'(code >> (8 * (int'(len) - 1 - i))), 1'b1, tde_pkg::STATUS_STORED,
                    i == int'(len) - 1);
      end
      bytes_used = bytes_used + tde_pkg::CAP_W'(len);
      last_dod   = dod;
      last_time  = ts;
    endfunction

    task report(string msg);
      $display("MISMATCH word %0d: %s", words_seen, msg);
      errors++;
    endtask

    task check_byte(logic [tde_pkg::BYTE_W-1:0] data, logic [2:0] user, logic last);
      enc_word_t e;
      words_seen++;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data=%h user=%b last=%b", data, user, last));
        return;
      end
      e = expected_words.pop_front();
      if (data !== e.data)
        report($sformatf("out_byte %h, expected %h", data, e.data));
      if (user[0] !== e.valid)
        report($sformatf("byte_valid %b, expected %b", user[0], e.valid));
      if (user[2:1] !== e.status)
        report($sformatf("status %0d, expected %s", user[2:1], e.status.name()));
      if (last !== e.last)
        report($sformatf("last %b, expected %b", last, e.last));
    endtask
  endclass

  delta_code_scoreboard sb = new();

  timestamp_delta_encoder_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [tde_pkg::TS_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(tde_pkg::cmd_t cmd, logic [tde_pkg::TS_W-1:0] ts);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= ts;
    do @(posedge clk); while (!s_tready);
    sb.note_timestamp(cmd, ts);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_dod(logic [tde_pkg::TS_W-1:0] dod);
    send_word(tde_pkg::CMD_APPEND, sb.last_time + sb.last_dod + dod);
  endtask

  task automatic send_random();
    int r;
    logic [tde_pkg::TS_W-1:0] dod;
    logic [tde_pkg::TS_W-1:0] edges [12];
    edges = '{64'd31, -64'sd32, 64'd32, -64'sd33, 64'd4095, -64'sd4096, 64'd4096,
              -64'sd4097, 64'd524287, -64'sd524288, 64'd524288, -64'sd524289};
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_word(tde_pkg::CMD_NEW_BLOCK, rand64());
      return;
    end
    if (r < 10) begin
      send_word(tde_pkg::CMD_APPEND, rand64());
      return;
    end
    if (r < 50)
      dod = 64'($urandom_range(0, 63)) - 64'd32;
    else if (r < 75)
      dod = 64'($urandom_range(0, 8191)) - 64'd4096;
    else if (r < 90)
      dod = 64'($urandom_range(0, 1048575)) - 64'd524288;
    else if (r < 96)
      dod = rand64();
    else
      dod = edges[$urandom_range(0, 11)];
    send_dod(dod);
  endtask

  task automatic wait_idle();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [tde_pkg::CAP_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_capacity(value);
    cfg_wen   <= 1'b0;
  endtask

  initial begin : sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser, m_tlast);
      if (rx_hold_req) begin
        stall = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else if (stall == 0) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timestamp_delta_encoder_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_word(tde_pkg::CMD_APPEND, '0);
    send_dod('0);
    send_dod(64'd31);
    send_dod(-64'sd32);
    send_dod(64'd32);
    send_dod(-64'sd33);
    send_dod(64'd4095);
    send_dod(-64'sd4096);
    send_dod(64'd4096);
    send_dod(-64'sd4097);
    send_dod(64'd524287);
    send_dod(-64'sd524288);
    send_dod(64'd524288);
    send_dod(-64'sd524289);
    send_dod(64'h7FFF_FFFF_FFFF_FFFF);
    send_dod(64'h8000_0000_0000_0000);
    send_word(tde_pkg::CMD_APPEND, '1);
    send_word(tde_pkg::CMD_NEW_BLOCK, '1);
    send_word(tde_pkg::CMD_APPEND, '1);
    send_word(tde_pkg::CMD_APPEND, '0);

    wait_idle();
    write_capacity(tde_pkg::CAP_W'(1));
    send_word(tde_pkg::CMD_NEW_BLOCK, '0);
    send_word(tde_pkg::CMD_APPEND, rand64());
    send_dod(64'd5);
    send_dod('0);
    send_dod(64'd4096);

    wait_idle();
    write_capacity('0);
    send_word(tde_pkg::CMD_NEW_BLOCK, '0);
    send_word(tde_pkg::CMD_APPEND, rand64());
    send_dod('0);

    wait_idle();
    write_capacity(tde_pkg::CAP_W'(20));
    repeat (60) send_random();

    wait_idle();
    write_capacity(tde_pkg::CAP_W'(1048576));
    repeat (60) send_random();

    wait_idle();
    write_capacity('1);
    no_idle = 1'b1;
    rx_hold_req = 1'b1;
    repeat (40) send_random();
    no_idle = 1'b0;
    wait_idle();
    repeat (60) send_random();
    no_idle = 1'b1;
    repeat (40) send_random();
    no_idle = 1'b0;

    // shrink below the bytes already held
    wait_idle();
    write_capacity(tde_pkg::CAP_W'(3));
    repeat (20) send_random();

    wait_idle();
    write_capacity(tde_pkg::CAP_RESET);
    repeat (50) send_random();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("timestamp_delta_encoder_core_tb OK");
    else
      $display("timestamp_delta_encoder_core_tb NOT OK");
    $finish;
  end

endmodule
